/* src/apt_pkg.sv */
// shared constants, codes and control types of the arrival presence tracker
package apt_pkg;

	// field widths
	localparam int MAC_W      = 48;
	localparam int TIME_W     = 32;
	localparam int TAG_W      = 8;
	localparam int OUT_SLOT_W = 3;
	localparam int REQ_W      = 2;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	// default table size
	localparam int SLOTS_DEF = 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_START = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PEER  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_END   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OBS_EN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE  = 2'd2;

	// configuration reset values
	localparam logic [CFG_W-1:0] THROTTLE_RST = 16'd100;
	localparam logic [CFG_W-1:0] MAX_AGE_RST  = 16'd5000;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic arrive;
	} sts_t;

endpackage

/* src/apt_ctrl.sv */
// controller state machine of the arrival presence tracker
module apt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output apt_pkg::cmd_t cmd,
	input  apt_pkg::sts_t sts,
	output logic          arrived_valid
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic valid_q;

	// command decode
	always_comb begin
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		case (state_q)
			ST_IDLE: cmd.capture = start;
			ST_EXEC: cmd.exec = 1'b1;
			default: cmd.exec = 1'b0;
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign arrived_valid = valid_q;

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.exec && sts.arrive;
			case (state_q)
				ST_IDLE: if (start) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* src/apt_dp.sv */
// slot table, tick state and result registers of the arrival presence tracker
module apt_dp #(
	parameter int SLOTS = apt_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  apt_pkg::cmd_t                   cmd,
	output apt_pkg::sts_t                   sts,
	input  logic [apt_pkg::REQ_W-1:0]       req_type,
	input  logic [apt_pkg::TIME_W-1:0]      now_ms,
	input  logic [apt_pkg::MAC_W-1:0]       mac,
	input  logic                            has_mac,
	input  logic [apt_pkg::TIME_W-1:0]      last_seen_ms,
	input  logic [apt_pkg::TAG_W-1:0]       peer_tag,
	input  logic                            cfg_we,
	input  logic [apt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apt_pkg::CFG_W-1:0]       cfg_data,
	output logic [apt_pkg::MAC_W-1:0]       arrived_mac,
	output logic [apt_pkg::OUT_SLOT_W-1:0]  arrived_slot,
	output logic [apt_pkg::TAG_W-1:0]       arrived_tag
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// configuration registers
	logic                        obs_en_q;
	logic [apt_pkg::CFG_W-1:0]   throttle_q;
	logic [apt_pkg::CFG_W-1:0]   max_age_q;

	// table and tick state
	logic [apt_pkg::MAC_W-1:0]   slot_addr_q [SLOTS];
	logic [SLOTS-1:0]            used_q;
	logic [SLOTS-1:0]            present_q;
	logic [apt_pkg::TIME_W-1:0]  last_tick_q;
	logic                        ever_q;
	logic                        open_q;

	// captured word
	logic [apt_pkg::REQ_W-1:0]   req_q;
	logic [apt_pkg::TIME_W-1:0]  now_q;
	logic [apt_pkg::MAC_W-1:0]   mac_q;
	logic                        has_mac_q;
	logic [apt_pkg::TAG_W-1:0]   tag_q;
	logic [SLOTS-1:0]            hit_q;
	logic                        fresh_q;
	logic                        throttled_q;

	// output registers
	logic [apt_pkg::MAC_W-1:0]      out_mac_q;
	logic [apt_pkg::OUT_SLOT_W-1:0] out_slot_q;
	logic [apt_pkg::TAG_W-1:0]      out_tag_q;

	logic [SLOTS-1:0]            hit_c;
	logic [apt_pkg::TIME_W-1:0]  age_c;
	logic [apt_pkg::TIME_W-1:0]  since_c;
	logic                        fresh_c;
	logic                        throttled_c;
	logic [SLOT_W-1:0]           free_idx;
	logic                        free_any;
	logic                        arrive_c;
	logic [SLOT_W+2:0]           slot_ext;

	// address match and time checks on the incoming word
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit_c[i] = used_q[i] && (slot_addr_q[i] == mac);
		end
		age_c       = now_ms - last_seen_ms;
		since_c     = now_ms - last_tick_q;
		fresh_c     = age_c <= {{(apt_pkg::TIME_W-apt_pkg::CFG_W){1'b0}}, max_age_q};
		throttled_c = ever_q &&
			(since_c < {{(apt_pkg::TIME_W-apt_pkg::CFG_W){1'b0}}, throttle_q});
	end

	// lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SLOT_W'(i);
				free_any = 1'b1;
			end
		end
	end

	// new peer that claims a slot
	assign arrive_c = (req_q == apt_pkg::REQ_PEER) && open_q && has_mac_q &&
		!(|hit_q) && fresh_q && free_any;
	assign sts.arrive = arrive_c;
	assign slot_ext   = {3'b000, free_idx};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_en_q   <= 1'b0;
			throttle_q <= apt_pkg::THROTTLE_RST;
			max_age_q  <= apt_pkg::MAX_AGE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				apt_pkg::CFG_OBS_EN:   obs_en_q   <= cfg_data[0];
				apt_pkg::CFG_THROTTLE: throttle_q <= cfg_data;
				apt_pkg::CFG_MAX_AGE:  max_age_q  <= cfg_data;
				default:               obs_en_q   <= obs_en_q;
			endcase
		end
	end

	// capture of the accepted word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q       <= req_type;
			now_q       <= now_ms;
			mac_q       <= mac;
			has_mac_q   <= has_mac;
			tag_q       <= peer_tag;
			hit_q       <= hit_c;
			fresh_q     <= fresh_c;
			throttled_q <= throttled_c;
		end
	end

	// tick and slot state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			present_q   <= '0;
			last_tick_q <= '0;
			ever_q      <= 1'b0;
			open_q      <= 1'b0;
		end else if (cmd.exec) begin
			case (req_q)
				apt_pkg::REQ_START: begin
					if (!obs_en_q || throttled_q) begin
						open_q <= 1'b0;
					end else begin
						last_tick_q <= now_q;
						ever_q      <= 1'b1;
						open_q      <= 1'b1;
						present_q   <= '0;
					end
				end
				apt_pkg::REQ_PEER: begin
					if (open_q && has_mac_q) begin
						if (|hit_q) begin
							present_q <= present_q | hit_q;
						end else if (arrive_c) begin
							used_q[free_idx]    <= 1'b1;
							present_q[free_idx] <= 1'b1;
						end
					end
				end
				apt_pkg::REQ_END: begin
					if (open_q) begin
						used_q <= used_q & present_q;
						open_q <= 1'b0;
					end
				end
				default: open_q <= open_q;
			endcase
		end
	end

	// slot addresses and result fields
	always_ff @(posedge clk) begin
		if (cmd.exec && arrive_c) begin
			slot_addr_q[free_idx] <= mac_q;
			out_mac_q             <= mac_q;
			out_slot_q            <= slot_ext[apt_pkg::OUT_SLOT_W-1:0];
			out_tag_q             <= tag_q;
		end
	end

	assign arrived_mac  = out_mac_q;
	assign arrived_slot = out_slot_q;
	assign arrived_tag  = out_tag_q;

endmodule

/* src/arrival_presence_tracker_top.sv */
// top level of the arrival presence tracker
//
// Keeps a table of SLOTS peer addresses with used and present marks.
// A word is taken on start while busy is low: req_type selects tick start,
// nearby peer entry or tick end; the other fields ride along with it.
// For each word the accept edge registers the address match against
// every slot and the two time checks, and the update edge that ends busy
// applies the update (free slot pick, mark set, tick open/close). busy is
// high for a single cycle per word; no new word is taken until it is low.
// A peer entry that claims a slot gives one arrival word: arrived_valid is
// high for exactly one cycle, the cycle after the update edge, with
// arrived_mac, arrived_slot and arrived_tag; the fields hold until the next
// arrival. The receiver cannot stall; it must take the word in that cycle.
// Configuration is written through cfg_we, cfg_index and cfg_data; the
// user must write it only while no word is in flight, as the block itself
// does not enforce this. Reset clears the marks, the tick state and the
// configuration to its defaults (observers off, throttle 100 ms, max age
// 5000 ms); the block takes words as soon as reset is released.
module arrival_presence_tracker_top #(
	parameter int SLOTS = apt_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [apt_pkg::REQ_W-1:0]       req_type,
	input  logic [apt_pkg::TIME_W-1:0]      now_ms,
	input  logic [apt_pkg::MAC_W-1:0]       mac,
	input  logic                            has_mac,
	input  logic [apt_pkg::TIME_W-1:0]      last_seen_ms,
	input  logic [apt_pkg::TAG_W-1:0]       peer_tag,
	input  logic                            cfg_we,
	input  logic [apt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apt_pkg::CFG_W-1:0]       cfg_data,
	output logic                            arrived_valid,
	output logic [apt_pkg::MAC_W-1:0]       arrived_mac,
	output logic [apt_pkg::OUT_SLOT_W-1:0]  arrived_slot,
	output logic [apt_pkg::TAG_W-1:0]       arrived_tag
);

	apt_pkg::cmd_t cmd;
	apt_pkg::sts_t sts;

	// sequencing
	apt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.sts           (sts),
		.arrived_valid (arrived_valid)
	);

	// table and result datapath
	apt_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req_type),
		.now_ms       (now_ms),
		.mac          (mac),
		.has_mac      (has_mac),
		.last_seen_ms (last_seen_ms),
		.peer_tag     (peer_tag),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.arrived_mac  (arrived_mac),
		.arrived_slot (arrived_slot),
		.arrived_tag  (arrived_tag)
	);

endmodule

/* src/apt_chk.sv */
// port-level checks of the arrival presence tracker, bound to the top level
module apt_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic arrived_valid
);

	// an accepted word keeps the block busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	// every word finishes after one busy cycle
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	// an arrival word follows directly on a busy cycle
	a_valid_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		arrived_valid |-> $past(busy) && !busy)
		else $error("arrival word not tied to a finished item");

	// arrival words are never back to back
	a_valid_single: assert property (@(posedge clk) disable iff (!arst_n)
		arrived_valid |=> !arrived_valid)
		else $error("arrival strobe longer than one cycle");

endmodule

bind arrival_presence_tracker_top apt_chk u_apt_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.arrived_valid (arrived_valid)
);

/* tb/arrival_presence_tracker_top_test.sv */
// self-checking testbench of the arrival presence tracker top level
module arrival_presence_tracker_top_test;
	import apt_pkg::*;

	localparam int SLOTS = SLOTS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE = 10;
	localparam int SETTLE_CYCLES = 4;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [TIME_W-1:0] now;
		logic [MAC_W-1:0]  mac;
		logic              has_mac;
		logic [TIME_W-1:0] seen;
		logic [TAG_W-1:0]  tag;
	} peer_word_t;

	typedef struct packed {
		logic [MAC_W-1:0]      mac;
		logic [OUT_SLOT_W-1:0] slot;
		logic [TAG_W-1:0]      tag;
	} arrival_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_W-1:0]      reg_val;
		peer_word_t            word;
		bit                    typed;
		bit                    typed_arrive;
		logic [OUT_SLOT_W-1:0] typed_slot;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [REQ_W-1:0]      req_type;
	logic [TIME_W-1:0]     now_ms;
	logic [MAC_W-1:0]      mac;
	logic                  has_mac;
	logic [TIME_W-1:0]     last_seen_ms;
	logic [TAG_W-1:0]      peer_tag;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  arrived_valid;
	logic [MAC_W-1:0]      arrived_mac;
	logic [OUT_SLOT_W-1:0] arrived_slot;
	logic [TAG_W-1:0]      arrived_tag;

	// tracker image kept by the testbench
	logic [MAC_W-1:0]  trk_addr [SLOTS];
	logic [SLOTS-1:0]  trk_used;
	logic [SLOTS-1:0]  trk_present;
	logic [TIME_W-1:0] trk_last_tick;
	logic              trk_ever_ticked;
	logic              trk_tick_open;
	logic              cfg_obs_en;
	logic [CFG_W-1:0]  cfg_throttle;
	logic [CFG_W-1:0]  cfg_max_age;

	arrival_t          arrivals_due [$];
	script_row_t       script [$];
	logic [MAC_W-1:0]  mac_pool [POOL_SIZE];
	logic [TIME_W-1:0] clock_ms;
	int unsigned       words_sent;
	int unsigned       arrivals_seen;
	int unsigned       mismatch_count;
	int unsigned       cycle_count;

	arrival_presence_tracker_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.now_ms(now_ms),
		.mac(mac),
		.has_mac(has_mac),
		.last_seen_ms(last_seen_ms),
		.peer_tag(peer_tag),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.arrived_valid(arrived_valid),
		.arrived_mac(arrived_mac),
		.arrived_slot(arrived_slot),
		.arrived_tag(arrived_tag)
	);

	// clock
	always #4 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// apply one word to the tracker image, return one when it arrives
	function automatic bit track_word(input peer_word_t w, output arrival_t got);
		int hit;
		int spot;
		logic [TIME_W-1:0] gap;
		got = '0;
		track_word = 1'b0;
		case (w.req)
			REQ_START: begin
				gap = w.now - trk_last_tick;
				if (!cfg_obs_en || (trk_ever_ticked && gap < 32'(cfg_throttle))) begin
					trk_tick_open = 1'b0;
				end else begin
					trk_last_tick = w.now;
					trk_ever_ticked = 1'b1;
					trk_tick_open = 1'b1;
					trk_present = '0;
				end
			end
			REQ_PEER: begin
				if (trk_tick_open && w.has_mac) begin
					hit = -1;
					spot = -1;
					for (int i = SLOTS - 1; i >= 0; i--) begin
						if (trk_used[i] && trk_addr[i] == w.mac)
							hit = i;
						if (!trk_used[i])
							spot = i;
					end
					gap = w.now - w.seen;
					if (hit >= 0) begin
						trk_present[hit] = 1'b1;
					end else if (gap <= 32'(cfg_max_age) && spot >= 0) begin
						trk_addr[spot] = w.mac;
						trk_used[spot] = 1'b1;
						trk_present[spot] = 1'b1;
						got.mac = w.mac;
						got.slot = OUT_SLOT_W'(spot);
						got.tag = w.tag;
						track_word = 1'b1;
					end
				end
			end
			REQ_END: begin
				// sweep out peers not seen in this tick
				if (trk_tick_open) begin
					trk_used = trk_used & trk_present;
					trk_tick_open = 1'b0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic script_row_t w_row(input logic [REQ_W-1:0] req,
			input logic [TIME_W-1:0] now, input logic [MAC_W-1:0] addr,
			input logic has, input logic [TIME_W-1:0] seen, input logic [TAG_W-1:0] tag);
		script_row_t r;
		r = '{default: '0};
		r.word = '{req: req, now: now, mac: addr, has_mac: has, seen: seen, tag: tag};
		return r;
	endfunction

	function automatic script_row_t t_row(input logic [REQ_W-1:0] req,
			input logic [TIME_W-1:0] now, input logic [MAC_W-1:0] addr,
			input logic has, input logic [TIME_W-1:0] seen, input logic [TAG_W-1:0] tag,
			input bit arrive, input logic [OUT_SLOT_W-1:0] slot);
		script_row_t r;
		r = w_row(req, now, addr, has, seen, tag);
		r.typed = 1'b1;
		r.typed_arrive = arrive;
		r.typed_slot = slot;
		return r;
	endfunction

	function automatic script_row_t c_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		script_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	function automatic peer_word_t noise_word();
		peer_word_t w;
		logic [63:0] r;
		r = {$urandom, $urandom};
		w.req = REQ_W'($urandom_range(3));
		w.now = $urandom;
		w.mac = r[MAC_W-1:0];
		w.has_mac = 1'($urandom_range(1));
		w.seen = $urandom;
		w.tag = TAG_W'($urandom);
		return w;
	endfunction

	task automatic flag_mismatch(input string text);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", text);
	endtask

	// drive one word, wait for its accept edge, then record what it should give
	task automatic send_word(input peer_word_t w, input bit typed, input bit typed_arrive,
			input logic [OUT_SLOT_W-1:0] typed_slot);
		arrival_t got;
		bit hit;
		@(negedge clk);
		start <= 1'b1;
		req_type <= w.req;
		now_ms <= w.now;
		mac <= w.mac;
		has_mac <= w.has_mac;
		last_seen_ms <= w.seen;
		peer_tag <= w.tag;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		hit = track_word(w, got);
		words_sent++;
		if (typed) begin
			if (typed_arrive)
				arrivals_due.push_back('{mac: w.mac, slot: typed_slot, tag: w.tag});
		end else if (hit) begin
			arrivals_due.push_back(got);
		end
	endtask

	task automatic sender_gap(input int unsigned pct);
		while ($urandom_range(99) < pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// hold off until every arrival has come, optionally until the block is idle
	task automatic wait_settled(input bit settle);
		@(negedge clk);
		start <= 1'b0;
		while (arrivals_due.size() != 0)
			@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_OBS_EN: cfg_obs_en = val[0];
			CFG_THROTTLE: cfg_throttle = val;
			CFG_MAX_AGE: cfg_max_age = val;
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one tick: sometimes a noise word, then start, a run of peer entries, usually an end sweep
	task automatic random_tick(input int unsigned gap_pct);
		peer_word_t w;
		logic [TIME_W-1:0] age;
		int unsigned entries;
		if ($urandom_range(9) == 0) begin
			sender_gap(gap_pct);
			send_word(noise_word(), 1'b0, 1'b0, '0);
		end
		w = noise_word();
		w.req = REQ_START;
		case ($urandom_range(9))
			0: clock_ms += $urandom;
			1, 2: clock_ms += $urandom_range(32'(cfg_throttle));
			default: clock_ms += 32'(cfg_throttle) + $urandom_range(300);
		endcase
		w.now = clock_ms;
		sender_gap(gap_pct);
		send_word(w, 1'b0, 1'b0, '0);
		entries = $urandom_range(10);
		repeat (entries) begin
			w = noise_word();
			w.req = REQ_PEER;
			clock_ms += $urandom_range(20);
			w.now = clock_ms;
			if ($urandom_range(3) != 0)
				w.mac = mac_pool[$urandom_range(POOL_SIZE - 1)];
			w.has_mac = ($urandom_range(9) != 0);
			case ($urandom_range(7))
				0: age = $urandom;
				1: age = 32'(cfg_max_age);
				2: age = 32'(cfg_max_age) + 32'd1;
				default: age = $urandom_range(32'(cfg_max_age));
			endcase
			w.seen = w.now - age;
			sender_gap(gap_pct);
			send_word(w, 1'b0, 1'b0, '0);
		end
		if ($urandom_range(99) < 85) begin
			w = noise_word();
			w.req = REQ_END;
			w.now = clock_ms;
			sender_gap(gap_pct);
			send_word(w, 1'b0, 1'b0, '0);
		end
		if ($urandom_range(99) < 3)
			wait_settled(1'b0);
	endtask

	task automatic run_phase(input int unsigned gap_pct, input logic obs,
			input logic [CFG_W-1:0] throttle, input logic [CFG_W-1:0] max_age,
			input int unsigned budget, input int unsigned need_arrivals);
		int unsigned first;
		logic [63:0] r;
		wait_settled(1'b1);
		write_reg(CFG_OBS_EN, CFG_W'(obs));
		write_reg(CFG_THROTTLE, throttle);
		write_reg(CFG_MAX_AGE, max_age);
		foreach (mac_pool[i]) begin
			r = {$urandom, $urandom};
			mac_pool[i] = r[MAC_W-1:0];
		end
		first = words_sent;
		while (words_sent - first < budget || arrivals_seen < need_arrivals)
			random_tick(gap_pct);
	endtask

	// result checker
	always @(posedge clk) begin
		arrival_t want;
		if (arst_n && arrived_valid) begin
			arrivals_seen++;
			if (arrivals_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected arrival: mac %h slot %0d tag %h",
					arrived_mac, arrived_slot, arrived_tag));
			end else begin
				want = arrivals_due.pop_front();
				if (want.mac !== arrived_mac || want.slot !== arrived_slot ||
						want.tag !== arrived_tag)
					flag_mismatch($sformatf(
						"arrival mismatch: want mac %h slot %0d tag %h, got mac %h slot %0d tag %h",
						want.mac, want.slot, want.tag, arrived_mac, arrived_slot, arrived_tag));
			end
		end
	end

	initial begin
		cycle_count = 0;
		words_sent = 0;
		arrivals_seen = 0;
		mismatch_count = 0;
		clock_ms = '0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_START;
		now_ms = '0;
		mac = '0;
		has_mac = 1'b0;
		last_seen_ms = '0;
		peer_tag = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_OBS_EN;
		cfg_data = '0;
		foreach (trk_addr[i])
			trk_addr[i] = '0;
		trk_used = '0;
		trk_present = '0;
		trk_last_tick = '0;
		trk_ever_ticked = 1'b0;
		trk_tick_open = 1'b0;
		cfg_obs_en = 1'b0;
		cfg_throttle = THROTTLE_RST;
		cfg_max_age = MAX_AGE_RST;

		// directed words: observers off, table fill, throttling, sweep, time wrap
		script = '{
			t_row(REQ_START, 32'd1000, 48'h0000_1111_2222, 1'b1, 32'd1000, 8'h01, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd1000, 48'h0000_1111_2222, 1'b1, 32'd1000, 8'h02, 1'b0, 3'd0),
			c_row(CFG_OBS_EN, 16'd1),
			t_row(REQ_START, 32'd0, 48'h0, 1'b0, 32'd0, 8'h00, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd0, 48'hFFFF_FFFF_FFFF, 1'b1, 32'd0, 8'hFF, 1'b1, 3'd0),
			t_row(REQ_PEER, 32'd5000, 48'h0, 1'b1, 32'd0, 8'h00, 1'b1, 3'd1),
			t_row(REQ_PEER, 32'd5001, 48'h1, 1'b1, 32'd0, 8'h11, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd0, 48'h2, 1'b0, 32'd0, 8'h12, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd10, 48'hFFFF_FFFF_FFFF, 1'b1, 32'd10, 8'h22, 1'b0, 3'd0),
			t_row(REQ_UNUSED, 32'hFFFF_FFFF, 48'h3, 1'b1, 32'hFFFF_FFFF, 8'h23, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd20, 48'hA5A5_0000_0003, 1'b1, 32'd20, 8'h30, 1'b1, 3'd2),
			t_row(REQ_PEER, 32'd20, 48'hA5A5_0000_0004, 1'b1, 32'd20, 8'h31, 1'b1, 3'd3),
			t_row(REQ_PEER, 32'd20, 48'hA5A5_0000_0005, 1'b1, 32'd20, 8'h32, 1'b1, 3'd4),
			t_row(REQ_PEER, 32'd20, 48'hA5A5_0000_0006, 1'b1, 32'd20, 8'h33, 1'b1, 3'd5),
			t_row(REQ_PEER, 32'd20, 48'hA5A5_0000_0007, 1'b1, 32'd20, 8'h34, 1'b1, 3'd6),
			t_row(REQ_PEER, 32'd20, 48'hA5A5_0000_0008, 1'b1, 32'd20, 8'h35, 1'b1, 3'd7),
			t_row(REQ_PEER, 32'd30, 48'h5A5A_5A5A_5A5A, 1'b1, 32'd30, 8'h36, 1'b0, 3'd0),
			t_row(REQ_END, 32'd40, 48'h0, 1'b0, 32'd0, 8'h00, 1'b0, 3'd0),
			t_row(REQ_START, 32'd50, 48'h0, 1'b0, 32'd0, 8'h00, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd60, 48'h9, 1'b1, 32'd60, 8'h40, 1'b0, 3'd0),
			t_row(REQ_START, 32'd100, 48'h0, 1'b0, 32'd0, 8'h00, 1'b0, 3'd0),
			t_row(REQ_PEER, 32'd100, 48'h0, 1'b1, 32'd0, 8'h41, 1'b0, 3'd0),
			t_row(REQ_END, 32'd100, 48'h0, 1'b0, 32'd0, 8'h00, 1'b0, 3'd0),
			w_row(REQ_START, 32'hFFFF_FFF0, 48'h0, 1'b0, 32'd0, 8'h00),
			w_row(REQ_PEER, 32'h0000_0010, 48'h8000_0000_0001, 1'b1, 32'hFFFF_FFF0, 8'h42),
			w_row(REQ_START, 32'h0000_0020, 48'h0, 1'b0, 32'd0, 8'h00)
		};

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				wait_settled(1'b1);
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_word(script[i].word, script[i].typed, script[i].typed_arrive,
					script[i].typed_slot);
			end
		end

		// random ticks under several settings, extremes first
		run_phase(18, 1'b1, 16'd0, 16'hFFFF, 180, 0);
		run_phase(74, 1'b1, 16'hFFFF, 16'd0, 180, 0);
		run_phase(0, 1'b0, THROTTLE_RST, MAX_AGE_RST, 30, 0);
		run_phase(0, 1'b1, CFG_W'($urandom_range(1, 500)), CFG_W'($urandom_range(3000)),
			180, 48);

		wait_settled(1'b1);
		if (arrivals_due.size() != 0)
			flag_mismatch($sformatf("%0d arrivals never came", arrivals_due.size()));
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* files.f */
src/apt_pkg.sv
src/apt_ctrl.sv
src/apt_dp.sv
src/arrival_presence_tracker_top.sv
src/apt_chk.sv
tb/arrival_presence_tracker_top_test.sv
